@@ src/swc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swc_pkg
// shared constants and register codes for the segment / wall crossing test
// ---------------------------------------------------------------------------
package swc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_ADDR_W      = 3;

    // minimum wall length is 0.01, compared on the squared length
    localparam longint unsigned SHORT_DIVISOR = 64'd10000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_START_Z = 3'd2,
        CFG_END_X   = 3'd3,
        CFG_END_Y   = 3'd4,
        CFG_END_Z   = 3'd5,
        CFG_HEIGHT  = 3'd6,
        CFG_ENABLE  = 3'd7
    } cfg_idx_t;

endpackage
`default_nettype wire

@@ src/swc_div_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swc_div_pipe
// restoring divider, one quotient bit per register stage, with side payload
// ---------------------------------------------------------------------------
module swc_div_pipe #(
    parameter int UW = 68,
    parameter int TW = 17,
    parameter int PW = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          ce,
    input  wire logic          in_valid,
    input  wire logic [UW-1:0] in_num,
    input  wire logic [UW-1:0] in_den,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_valid,
    output logic [TW-1:0]      out_quo,
    output logic [PW-1:0]      out_pay
);

    for (genvar i = 0; i < TW; i++) begin : g_stage
        logic [UW:0]   rem_cur;
        logic [UW-1:0] den_cur;
        logic [TW-1:0] quo_cur;
        logic [PW-1:0] pay_cur;
        logic          vld_cur;
        logic          ge;
        logic [TW-1:0] quo_reg;
        logic [PW-1:0] pay_reg;
        logic          vld_reg;

        if (i == 0) begin : g_first
            assign rem_cur = {1'b0, in_num};
            assign den_cur = in_den;
            assign quo_cur = '0;
            assign pay_cur = in_pay;
            assign vld_cur = in_valid;
        end else begin : g_next
            assign rem_cur = g_stage[i-1].g_carry.rem_reg;
            assign den_cur = g_stage[i-1].g_carry.den_reg;
            assign quo_cur = g_stage[i-1].quo_reg;
            assign pay_cur = g_stage[i-1].pay_reg;
            assign vld_cur = g_stage[i-1].vld_reg;
        end

        assign ge = rem_cur >= {1'b0, den_cur};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (ce) begin
                vld_reg <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                quo_reg <= {quo_cur[TW-2:0], ge};
                pay_reg <= pay_cur;
            end
        end

        // partial remainder and divisor only travel on to a following stage
        if (i < TW - 1) begin : g_carry
            logic [UW-1:0] rem_sub;
            logic [UW:0]   rem_reg;
            logic [UW-1:0] den_reg;

            assign rem_sub = ge ? UW'(rem_cur - {1'b0, den_cur}) : rem_cur[UW-1:0];

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg <= {rem_sub, 1'b0};
                    den_reg <= den_cur;
                end
            end
        end
    end

    assign out_valid = g_stage[TW-1].vld_reg;
    assign out_quo   = g_stage[TW-1].quo_reg;
    assign out_pay   = g_stage[TW-1].pay_reg;

endmodule
`default_nettype wire

@@ src/segment_wall_crossing_test_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// segment_wall_crossing_test_core
// tests one movement segment per request against a configured vertical wall
//
//  channel  | dir | content
//  s_       | in  | from_x, from_y, from_z, to_x, to_y, to_z
//  m_       | out | crosses
//  cfg_     | in  | wall registers, write only
//
// one request enters per cycle while m_tready does not stall; the pipeline is
// the one-bit-per-stage divider for the crossing fraction plus eight stages of
// differences, products and compares around it
// reset clears the valid bits and loads the wall registers (enable set)
// a stall on m_tready freezes the whole pipeline; s_tready follows it
// ---------------------------------------------------------------------------
module segment_wall_crossing_test_core #(
    parameter int COORD_WIDTH = swc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = swc_pkg::FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // from_x, from_y, from_z, to_x, to_y, to_z
    input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // crosses
    output logic [7:0] m_tdata,
    input  wire logic cfg_wr_en,
    input  wire logic [swc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [COORD_WIDTH-1:0] cfg_wr_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int DW  = CW + 1;
    localparam int PW2 = 2 * DW;
    localparam int DDW = PW2 + 1;
    localparam int UW  = DDW + 1;
    localparam int LW  = 2 * CW + 2;
    localparam int TW  = FB + 1;
    localparam int AW  = CW + 3;
    localparam int MW  = AW + DW;
    localparam int OW  = MW + 2;
    localparam int PAYW = 3 * CW + 9 * DW + LW + 1;
    localparam longint unsigned SHORT_LIM =
        ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / swc_pkg::SHORT_DIVISOR;

    // wall registers
    logic signed [CW-1:0] ws_reg [3];
    logic signed [CW-1:0] we_reg [3];
    logic [CW-2:0]        height_reg;
    logic                 enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                ws_reg[k] <= '0;
                we_reg[k] <= '0;
            end
            height_reg <= '0;
            enable_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (swc_pkg::cfg_idx_t'(cfg_addr))
                swc_pkg::CFG_START_X: ws_reg[0]  <= cfg_wr_data;
                swc_pkg::CFG_START_Y: ws_reg[1]  <= cfg_wr_data;
                swc_pkg::CFG_START_Z: ws_reg[2]  <= cfg_wr_data;
                swc_pkg::CFG_END_X:   we_reg[0]  <= cfg_wr_data;
                swc_pkg::CFG_END_Y:   we_reg[1]  <= cfg_wr_data;
                swc_pkg::CFG_END_Z:   we_reg[2]  <= cfg_wr_data;
                swc_pkg::CFG_HEIGHT:  height_reg <= cfg_wr_data[CW-2:0];
                swc_pkg::CFG_ENABLE:  enable_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    logic ce;
    logic out_valid_reg;
    logic crosses_reg;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    logic signed [CW-1:0] in_p [3];
    logic signed [CW-1:0] in_q [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_p[k] = s_tdata[k*CW +: CW];
            in_q[k] = s_tdata[(k+3)*CW +: CW];
        end
    end

    // stage 1: differences against the wall
    logic                 v1_reg;
    logic signed [CW-1:0] p1_reg [3];
    logic signed [CW-1:0] q1_reg [3];
    logic signed [DW-1:0] dir1_reg [3];
    logic signed [DW-1:0] ps1_reg [3];
    logic signed [DW-1:0] qs1_reg [3];
    logic signed [DW-1:0] se1_reg [3];
    logic signed [DW-1:0] sy1_reg;
    logic signed [DW-1:0] top1_reg;
    logic                 en1_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                p1_reg[k]   <= in_p[k];
                q1_reg[k]   <= in_q[k];
                dir1_reg[k] <= DW'(we_reg[k]) - DW'(ws_reg[k]);
                ps1_reg[k]  <= DW'(in_p[k]) - DW'(ws_reg[k]);
                qs1_reg[k]  <= DW'(in_q[k]) - DW'(ws_reg[k]);
                se1_reg[k]  <= DW'(ws_reg[k]) + DW'(we_reg[k]);
            end
            sy1_reg  <= DW'(ws_reg[1]);
            top1_reg <= DW'(ws_reg[1]) + $signed({2'b00, height_reg});
            en1_reg  <= enable_reg;
        end
    end

    // stage 2: plane and length products, height band
    logic                  v2_reg;
    logic signed [CW-1:0]  p2_reg [3];
    logic signed [CW-1:0]  q2_reg [3];
    logic signed [DW-1:0]  dir2_reg [3];
    logic signed [DW-1:0]  se2_reg [3];
    logic signed [PW2-1:0] pa2_reg, pb2_reg, qa2_reg, qb2_reg;
    logic signed [PW2-1:0] sq2_reg [3];
    logic                  band_rej2_reg;
    logic                  en2_reg;

    logic signed [CW-1:0] miny1, maxy1;
    assign miny1 = (p1_reg[1] < q1_reg[1]) ? p1_reg[1] : q1_reg[1];
    assign maxy1 = (p1_reg[1] < q1_reg[1]) ? q1_reg[1] : p1_reg[1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                p2_reg[k]   <= p1_reg[k];
                q2_reg[k]   <= q1_reg[k];
                dir2_reg[k] <= dir1_reg[k];
                se2_reg[k]  <= se1_reg[k];
                sq2_reg[k]  <= dir1_reg[k] * dir1_reg[k];
            end
            pa2_reg <= ps1_reg[0] * dir1_reg[2];
            pb2_reg <= ps1_reg[2] * dir1_reg[0];
            qa2_reg <= qs1_reg[0] * dir1_reg[2];
            qb2_reg <= qs1_reg[2] * dir1_reg[0];
            band_rej2_reg <= (DW'(maxy1) < sy1_reg) || (DW'(miny1) > top1_reg);
            en2_reg <= en1_reg;
        end
    end

    // stage 3: plane distances and squared length
    logic                  v3_reg;
    logic signed [CW-1:0]  p3_reg [3];
    logic signed [CW-1:0]  q3_reg [3];
    logic signed [DW-1:0]  dir3_reg [3];
    logic signed [DW-1:0]  se3_reg [3];
    logic signed [DDW-1:0] d1_3_reg, d2_3_reg;
    logic [LW-1:0]         lensq3_reg;
    logic                  band_rej3_reg;
    logic                  en3_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                p3_reg[k]   <= p2_reg[k];
                q3_reg[k]   <= q2_reg[k];
                dir3_reg[k] <= dir2_reg[k];
                se3_reg[k]  <= se2_reg[k];
            end
            d1_3_reg <= DDW'(pa2_reg) - DDW'(pb2_reg);
            d2_3_reg <= DDW'(qa2_reg) - DDW'(qb2_reg);
            lensq3_reg <= LW'(sq2_reg[0]) + LW'(sq2_reg[1]) + LW'(sq2_reg[2]);
            band_rej3_reg <= band_rej2_reg;
            en3_reg <= en2_reg;
        end
    end

    // stage 4: early rejects, divider operands
    logic                 v4_reg;
    logic signed [CW-1:0] p4_reg [3];
    logic signed [DW-1:0] delta4_reg [3];
    logic signed [DW-1:0] dir4_reg [3];
    logic signed [DW-1:0] se4_reg [3];
    logic [LW-1:0]        lensq4_reg;
    logic [UW-1:0]        num4_reg, den4_reg;
    logic                 ok4_reg;

    logic signed [UW-1:0] d1e, dd;
    logic                 z1, z2, plane_rej, short_wall;
    assign d1e = UW'(d1_3_reg);
    assign dd  = UW'(d1_3_reg) - UW'(d2_3_reg);
    assign z1  = (d1_3_reg == '0);
    assign z2  = (d2_3_reg == '0);
    // both in plane, or strictly on the same side
    assign plane_rej = (z1 && z2) ||
                       (!z1 && !z2 && (d1_3_reg[DDW-1] == d2_3_reg[DDW-1]));
    assign short_wall = {64'd0, lensq3_reg} <= {{LW{1'b0}}, SHORT_LIM};

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                p4_reg[k]     <= p3_reg[k];
                delta4_reg[k] <= DW'(q3_reg[k]) - DW'(p3_reg[k]);
                dir4_reg[k]   <= dir3_reg[k];
                se4_reg[k]    <= se3_reg[k];
            end
            lensq4_reg <= lensq3_reg;
            num4_reg   <= d1e[UW-1] ? UW'(-d1e) : UW'(d1e);
            den4_reg   <= dd[UW-1] ? UW'(-dd) : UW'(dd);
            ok4_reg    <= en3_reg && !short_wall && !plane_rej && !band_rej3_reg;
        end
    end

    // crossing fraction
    logic [PAYW-1:0] pay_in, pay_out;
    logic            dv;
    logic [TW-1:0]   t_q;

    assign pay_in = {ok4_reg, lensq4_reg,
                     dir4_reg[2], dir4_reg[1], dir4_reg[0],
                     se4_reg[2], se4_reg[1], se4_reg[0],
                     delta4_reg[2], delta4_reg[1], delta4_reg[0],
                     p4_reg[2], p4_reg[1], p4_reg[0]};

    swc_div_pipe #(
        .UW (UW),
        .TW (TW),
        .PW (PAYW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_den    (den4_reg),
        .in_pay    (pay_in),
        .out_valid (dv),
        .out_quo   (t_q),
        .out_pay   (pay_out)
    );

    logic signed [CW-1:0] pd_p [3];
    logic signed [DW-1:0] pd_delta [3];
    logic signed [DW-1:0] pd_dir [3];
    logic signed [DW-1:0] pd_se [3];
    logic [LW-1:0]        pd_lensq;
    logic                 pd_ok;

    assign {pd_ok, pd_lensq, pd_dir[2], pd_dir[1], pd_dir[0],
            pd_se[2], pd_se[1], pd_se[0],
            pd_delta[2], pd_delta[1], pd_delta[0],
            pd_p[2], pd_p[1], pd_p[0]} = pay_out;

    // stage L1: |delta| * t
    logic                 vl1_reg;
    logic [DW+TW-1:0]     lp1_reg [3];
    logic                 neg1_reg [3];
    logic signed [CW-1:0] pl1_reg [3];
    logic signed [DW-1:0] dirl1_reg [3];
    logic signed [DW-1:0] sel1_reg [3];
    logic [LW-1:0]        lensql1_reg;
    logic                 okl1_reg;

    logic [DW-1:0] magd [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            magd[k] = pd_delta[k][DW-1] ? DW'(-pd_delta[k]) : DW'(pd_delta[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                lp1_reg[k]   <= (DW+TW)'(magd[k]) * (DW+TW)'(t_q);
                neg1_reg[k]  <= pd_delta[k][DW-1];
                pl1_reg[k]   <= pd_p[k];
                dirl1_reg[k] <= pd_dir[k];
                sel1_reg[k]  <= pd_se[k];
            end
            lensql1_reg <= pd_lensq;
            okl1_reg    <= pd_ok;
        end
    end

    // stage L2: crossing point, offset from the wall midpoint (doubled)
    logic                 vl2_reg;
    logic signed [AW-1:0] a2_reg [3];
    logic signed [DW-1:0] dirl2_reg [3];
    logic [LW-1:0]        lensql2_reg;
    logic                 okl2_reg;

    logic [DW:0]          step [3];
    logic signed [AW-1:0] cross_pt [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            step[k]     = lp1_reg[k][DW+TW-1:FB];
            cross_pt[k] = neg1_reg[k] ? AW'(pl1_reg[k]) - $signed({1'b0, step[k]})
                                      : AW'(pl1_reg[k]) + $signed({1'b0, step[k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                a2_reg[k]    <= (cross_pt[k] <<< 1) - AW'(sel1_reg[k]);
                dirl2_reg[k] <= dirl1_reg[k];
            end
            lensql2_reg <= lensql1_reg;
            okl2_reg    <= okl1_reg;
        end
    end

    // stage D1: projection products
    logic                 vd1_reg;
    logic signed [MW-1:0] pr_reg [3];
    logic [LW-1:0]        lensqd_reg;
    logic                 okd_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                pr_reg[k] <= MW'(a2_reg[k]) * MW'(dirl2_reg[k]);
            end
            lensqd_reg <= lensql2_reg;
            okd_reg    <= okl2_reg;
        end
    end

    // stage D2: |dot| against squared length, output register
    logic signed [OW-1:0] dot;
    logic [OW-1:0]        dot_mag;
    assign dot     = OW'(pr_reg[0]) + OW'(pr_reg[1]) + OW'(pr_reg[2]);
    assign dot_mag = dot[OW-1] ? OW'(-dot) : OW'(dot);

    always_ff @(posedge aclk) begin
        if (ce) begin
            crosses_reg <= okd_reg && (dot_mag <= OW'(lensqd_reg));
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            vl1_reg       <= 1'b0;
            vl2_reg       <= 1'b0;
            vd1_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            vl1_reg       <= dv;
            vl2_reg       <= vl1_reg;
            vd1_reg       <= vl2_reg;
            out_valid_reg <= vd1_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, crosses_reg};

endmodule
`default_nettype wire

@@ tb/sv/segment_wall_crossing_test_core_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_wall_crossing_test_core_checker
// watches the wall register writes and both stream channels, works out the
// crossing flag of every accepted request and compares it with the result
// ---------------------------------------------------------------------------
module segment_wall_crossing_test_core_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wr_data,
    output int           fail_count,
    output int           pending
);

    typedef logic signed [127:0] wide_t;

    logic signed [31:0] wall_s [3];
    logic signed [31:0] wall_e [3];
    logic [30:0]        wall_h;
    logic               wall_on;
    bit                 crossing_q[$];

    function automatic wide_t magw(wide_t v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit segment_crosses(logic [191:0] seg);
        wide_t s[3], e[3], p[3], q[3], dir[3], a[3];
        wide_t lensq, d1, d2, ud1, ud, t, dlt, prod, dot, miny, maxy;
        if (!wall_on) return 0;
        for (int i = 0; i < 3; i++) begin
            s[i]   = wall_s[i];
            e[i]   = wall_e[i];
            p[i]   = $signed(seg[32*i +: 32]);
            q[i]   = $signed(seg[32*(i+3) +: 32]);
            dir[i] = e[i] - s[i];
        end
        lensq = dir[0]*dir[0] + dir[1]*dir[1] + dir[2]*dir[2];
        if (lensq * 10000 < (wide_t'(1) <<< (2*FRAC_BITS))) return 0;
        // normal is (dz, 0, -dx)
        d1 = (p[0]-s[0])*dir[2] - (p[2]-s[2])*dir[0];
        d2 = (q[0]-s[0])*dir[2] - (q[2]-s[2])*dir[0];
        if (d1 == 0 && d2 == 0) return 0;
        if (d1 != 0 && d2 != 0 && ((d1 < 0) == (d2 < 0))) return 0;
        miny = p[1] < q[1] ? p[1] : q[1];
        maxy = p[1] < q[1] ? q[1] : p[1];
        if (maxy < s[1] || miny > s[1] + wide_t'(wall_h)) return 0;
        ud1 = magw(d1);
        ud  = magw(d1 - d2);
        t   = (ud1 <<< FRAC_BITS) / ud;
        for (int i = 0; i < 3; i++) begin
            dlt  = q[i] - p[i];
            prod = (magw(dlt) * t) >>> FRAC_BITS;
            a[i] = 2 * (dlt < 0 ? p[i] - prod : p[i] + prod) - s[i] - e[i];
        end
        dot = magw(a[0]*dir[0] + a[1]*dir[1] + a[2]*dir[2]);
        return lensq >= dot;
    endfunction

    assign pending = crossing_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                wall_s[i] = '0;
                wall_e[i] = '0;
            end
            wall_h  = '0;
            wall_on = 1'b1;
            crossing_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (swc_pkg::cfg_idx_t'(cfg_addr))
                    swc_pkg::CFG_START_X: wall_s[0] = cfg_wr_data;
                    swc_pkg::CFG_START_Y: wall_s[1] = cfg_wr_data;
                    swc_pkg::CFG_START_Z: wall_s[2] = cfg_wr_data;
                    swc_pkg::CFG_END_X:   wall_e[0] = cfg_wr_data;
                    swc_pkg::CFG_END_Y:   wall_e[1] = cfg_wr_data;
                    swc_pkg::CFG_END_Z:   wall_e[2] = cfg_wr_data;
                    swc_pkg::CFG_HEIGHT:  wall_h    = cfg_wr_data[30:0];
                    swc_pkg::CFG_ENABLE:  wall_on   = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (crossing_q.size() == 0) begin
                    $error("result with no request waiting: crosses=%0d", m_tdata[0]);
                    fail_count++;
                end else begin
                    bit want;
                    want = crossing_q.pop_front();
                    if (m_tdata[0] !== want) begin
                        $error("crosses: expected %0d, got %0d", want, m_tdata[0]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) crossing_q = {crossing_q, segment_crosses(s_tdata)};
        end
    end
endmodule

@@ tb/sv/segment_wall_crossing_test_core_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_wall_crossing_test_core_test
// drives directed and random segments against a series of wall settings,
// with bursty requests and a stalling receiver; the checker gives the verdict
// ---------------------------------------------------------------------------
module segment_wall_crossing_test_core_test;

    localparam int FRAC     = 16;
    localparam int LATENCY  = FRAC + 9;
    localparam int MIN32    = 32'h8000_0000;
    localparam int MAX32    = 32'h7FFF_FFFF;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [7:0]   m_tdata;
    logic         cfg_wr_en = 0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wr_data = '0;
    int           fail_count;
    int           pending;
    bit           hold_req = 0;
    int           burst_left = 0;
    longint       ws[3], we[3], wh;

    segment_wall_crossing_test_core u_top (.*);

    segment_wall_crossing_test_core_checker #(.FRAC_BITS(FRAC)) u_checker (.*);

    initial forever #5 aclk = ~aclk;

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: alternating free and stalling stretches, plus one long hold-off
    initial begin
        int mode_left, mode;
        mode_left = 0;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            m_tready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 3) != 0)
                                                       : ($urandom_range(0, 3) == 0);
        end
    end

    task automatic send_seg(longint fx, fy, fz, tx, ty, tz);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {tz[31:0], ty[31:0], tx[31:0], fz[31:0], fy[31:0], fx[31:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic reg_write(swc_pkg::cfg_idx_t idx, longint val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val[31:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            swc_pkg::CFG_START_X: ws[0] = longint'($signed(val[31:0]));
            swc_pkg::CFG_START_Y: ws[1] = longint'($signed(val[31:0]));
            swc_pkg::CFG_START_Z: ws[2] = longint'($signed(val[31:0]));
            swc_pkg::CFG_END_X:   we[0] = longint'($signed(val[31:0]));
            swc_pkg::CFG_END_Y:   we[1] = longint'($signed(val[31:0]));
            swc_pkg::CFG_END_Z:   we[2] = longint'($signed(val[31:0]));
            swc_pkg::CFG_HEIGHT:  wh    = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_wall(longint sx, sy, sz, ex, ey, ez, h, bit on);
        drain();
        reg_write(swc_pkg::CFG_START_X, sx);
        reg_write(swc_pkg::CFG_START_Y, sy);
        reg_write(swc_pkg::CFG_START_Z, sz);
        reg_write(swc_pkg::CFG_END_X, ex);
        reg_write(swc_pkg::CFG_END_Y, ey);
        reg_write(swc_pkg::CFG_END_Z, ez);
        reg_write(swc_pkg::CFG_HEIGHT, h);
        reg_write(swc_pkg::CFG_ENABLE, on);
    endtask

    function automatic longint spread(int r);
        return longint'($urandom_range(0, 2*r)) - r;
    endfunction

    // segment through a point near the wall, mostly across the plane
    task automatic wall_seg;
        longint u, ix, iy, iz, k1, k2, nx, nz, side;
        u  = longint'($urandom_range(0, 400)) - 60;
        ix = ws[0] + (we[0] - ws[0]) * u / 256;
        iz = ws[2] + (we[2] - ws[2]) * u / 256;
        iy = ws[1] + spread(int'(wh / 2 + 64)) + wh / 2;
        nx = we[2] - ws[2];
        nz = -(we[0] - ws[0]);
        k1 = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 256);
        k2 = $urandom_range(1, 256);
        side = $urandom_range(0, 6) == 0 ? 1 : -1;
        send_seg(ix + nx*k1/256 + spread(3), iy + spread(int'(wh + 16)), iz + nz*k1/256,
                 ix + side*nx*k2/256, iy + spread(int'(wh + 16)), iz + side*nz*k2/256);
    endtask

    task automatic noise_seg;
        send_seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        ws = '{0, 0, 0}; we = '{0, 0, 0}; wh = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset wall is zero length: never a hit
        send_seg(0, 0, 0, 65536, 0, 0);
        send_seg(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32);

        // wall along x from 0 to 10, height 4, crossing in z
        set_wall(0, 0, 0, 10 <<< 16, 0, 0, 4 <<< 16, 1);
        send_seg(5 <<< 16, 1 <<< 16, -(1 <<< 16), 5 <<< 16, 1 <<< 16, 1 <<< 16);
        send_seg(5 <<< 16, 1 <<< 16, 0, 5 <<< 16, 1 <<< 16, 3 <<< 16);  // endpoint on plane
        send_seg(1 <<< 16, 1 <<< 16, 0, 9 <<< 16, 2 <<< 16, 0);          // in plane
        send_seg(5 <<< 16, 1 <<< 16, 1 <<< 16, 6 <<< 16, 1 <<< 16, 2 <<< 16); // same side
        send_seg(5 <<< 16, 9 <<< 16, -(1 <<< 16), 5 <<< 16, 8 <<< 16, 1 <<< 16); // above
        send_seg(5 <<< 16, -(3 <<< 16), -(1 <<< 16), 5 <<< 16, -(1 <<< 16), 1 <<< 16);
        send_seg(5 <<< 16, 4 <<< 16, -(1 <<< 16), 5 <<< 16, 4 <<< 16, 1 <<< 16); // top edge
        send_seg(0, 0, -(1 <<< 16), 0, 0, 1 <<< 16);                      // wall start
        send_seg(10 <<< 16, 0, -(1 <<< 16), 10 <<< 16, 0, 1 <<< 16);      // wall end
        send_seg(11 <<< 16, 0, -(1 <<< 16), 11 <<< 16, 0, 1 <<< 16);      // past end
        send_seg(MIN32, 0, MIN32, MAX32, MAX32, MAX32);
        send_seg(MAX32, MIN32, MAX32, MIN32, MAX32, MIN32);
        send_seg(-1, -1, -1, 0, 0, 0);

        // short wall just below and above 0.01
        set_wall(0, 0, 0, 650, 0, 0, 4 <<< 16, 1);
        send_seg(300, 0, -100, 300, 0, 100);
        set_wall(0, 0, 0, 660, 0, 0, 4 <<< 16, 1);
        send_seg(300, 0, -100, 300, 0, 100);
        // vertical wall with no horizontal extent
        set_wall(0, 0, 0, 0, 5 <<< 16, 0, 4 <<< 16, 1);
        send_seg(0, 0, -100, 0, 0, 100);
        // disabled wall
        set_wall(0, 0, 0, 10 <<< 16, 0, 0, 4 <<< 16, 0);
        send_seg(5 <<< 16, 1 <<< 16, -(1 <<< 16), 5 <<< 16, 1 <<< 16, 1 <<< 16);
        // extreme wall coordinates and full height
        set_wall(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32, MAX32, 1);
        send_seg(0, 0, MIN32, 0, 0, MAX32);
        send_seg(MIN32, MIN32, MAX32, MAX32, MAX32, MIN32);
        noise_seg();

        // random phases: small walls (full range in the last) with structured segments, some noise
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 9)
                set_wall($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, 1);
            else
                set_wall(spread(1 << 22), spread(1 << 22), spread(1 << 22),
                         spread(1 << 22), spread(1 << 22), spread(1 << 22),
                         $urandom_range(0, 1 << 21), ph != 4);
            if (ph == 3) hold_req = 1;
            for (int n = 0; n < 53; n++) begin
                if ($urandom_range(0, 4) == 0) noise_seg();
                else wall_seg();
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
